[sv/cnsp_pkg.sv]
// Package for the newc cpio stream parser: phase encoding, result kinds,
// error codes and the small character tables. No dependencies.

package cnsp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_HEX   = 4'd1,
        PH_NAME  = 4'd2,
        PH_NUL   = 4'd3,
        PH_PAD1  = 4'd4,
        PH_DATA  = 4'd5,
        PH_PAD2  = 4'd6,
        PH_DONE  = 4'd7,
        PH_ERROR = 4'd8
    } t_phase;

    // result kinds
    localparam logic [2:0] K_HEADER  = 3'd0;
    localparam logic [2:0] K_NAME    = 3'd1;
    localparam logic [2:0] K_START   = 3'd2;
    localparam logic [2:0] K_TRAILER = 3'd3;
    localparam logic [2:0] K_PAD     = 3'd4;
    localparam logic [2:0] K_DATA    = 3'd5;
    localparam logic [2:0] K_ERROR   = 3'd6;
    localparam logic [2:0] K_IGNORED = 3'd7;

    // error codes
    localparam logic [3:0] E_NONE    = 4'd0;
    localparam logic [3:0] E_MAGIC   = 4'd1;
    localparam logic [3:0] E_HEXDIG  = 4'd2;
    localparam logic [3:0] E_HEXNUM  = 4'd3;
    localparam logic [3:0] E_NAMELEN = 4'd4;
    localparam logic [3:0] E_ZERO    = 4'd5;
    localparam logic [3:0] E_SPACE   = 4'd6;
    localparam logic [3:0] E_UNPRINT = 4'd7;
    localparam logic [3:0] E_NOTERM  = 4'd8;

    localparam int MAGIC_LEN   = 6;
    localparam int TRAILER_LEN = 10;
    localparam int HEX_FIELDS  = 13;
    localparam int HEX_DIGITS  = 8;
    localparam int SIZE_FIELD  = 6;
    localparam int NAME_FIELD  = 11;

    // expected magic character at a position ("070701")
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd1:    ch = "7";
            3'd3:    ch = "7";
            3'd5:    ch = "1";
            default: ch = "0";
        endcase
        return ch;
    endfunction

    // expected trailer name character at a position ("TRAILER!!!")
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "T";
            4'd1:    ch = "R";
            4'd2:    ch = "A";
            4'd3:    ch = "I";
            4'd4:    ch = "L";
            4'd5:    ch = "E";
            4'd6:    ch = "R";
            default: ch = "!";
        endcase
        return ch;
    endfunction

    // {ok, value} of an ASCII hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

[sv/cpio_newc_stream_parser_unit.sv]
// Top level of the newc cpio stream parser: one archive byte in, one
// classified result out. Depends on cnsp_pkg.

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall   | i_stream_byte
//  result  | out       | o_valid / i_stall   | o_kind, o_byte_out, o_member_length,
//          |           |                     | o_error_code, o_last_data
//
//  Each accepted byte is decoded in the cycle it arrives and its result lands
//  in the output register on the same edge.
//  A byte is taken in every cycle while the output register is empty or being
//  drained, so the sustained rate is one byte per clock.
//  o_stall rises only when a result sits in the output register and the
//  downstream side stalls it.
//  Synchronous active-low reset returns the parser to the magic phase with
//  all counters cleared and the error latch empty.

module cpio_newc_stream_parser_unit
    import cnsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_out,
    output logic [31:0] o_member_length,
    output logic [3:0]  o_error_code,
    output logic        o_last_data
);

    // parser state
    t_phase      r_phase,         n_phase;
    logic [3:0]  r_field_index,   n_field_index;
    logic [2:0]  r_digit_index,   n_digit_index;
    logic        r_leading,       n_leading;
    logic [31:0] r_field_value,   n_field_value;
    logic [31:0] r_member_size,   n_member_size;
    logic [31:0] r_name_left,     n_name_left;
    logic [31:0] r_data_left,     n_data_left;
    logic [1:0]  r_offset_low,    n_offset_low;
    logic        r_trailer_match, n_trailer_match;
    logic [3:0]  r_name_position, n_name_position;
    logic [3:0]  r_err,           n_err;

    // result register
    logic        r_valid;
    logic [2:0]  r_kind,          n_kind;
    logic [7:0]  r_byte_out,      n_byte_out;
    logic [31:0] r_member_length, n_member_length;
    logic [3:0]  r_error_code,    n_error_code;
    logic        r_last_data,     n_last_data;

    // decode of the current byte
    logic [7:0]  w_c;
    logic        w_accept;
    logic        w_space;
    logic [4:0]  w_hex;
    logic [31:0] w_shifted;
    logic        w_digit_last;
    logic        w_field_done;
    logic        w_hdr_done;
    logic        w_is_trailer;
    logic        w_data_last;
    logic        w_err_hit;
    logic [3:0]  w_err_code;

    assign w_c      = i_stream_byte;
    // take a byte unless a stalled result still occupies the output register
    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // ---------------------------------------------------------------
    // Byte classification and error detection for the current phase
    // ---------------------------------------------------------------
    always_comb begin
        w_space      = (w_c == 8'h20);
        w_hex        = hex_value(w_c);
        // a leading space counts as a zero digit
        w_shifted    = {r_field_value[27:0], (w_space ? 4'd0 : w_hex[3:0])};
        w_digit_last = (r_digit_index == 3'(HEX_DIGITS - 1));
        w_field_done = w_digit_last && !(w_space && r_leading);
        w_is_trailer = r_trailer_match && (r_name_position == 4'(TRAILER_LEN));
        w_data_last  = (r_data_left == 32'd1);
        w_hdr_done   = 1'b0;
        w_err_hit    = 1'b0;
        w_err_code   = E_NONE;
        case (r_phase)
            PH_MAGIC: begin
                if (w_c != magic_char(r_field_index[2:0])) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_MAGIC;
                end
            end
            PH_HEX: begin
                if (w_space && !r_leading) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_HEXNUM;
                end else if (!w_space && !w_hex[4]) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_HEXDIG;
                end else if (w_digit_last && w_space && r_leading) begin
                    // field made only of spaces
                    w_err_hit  = 1'b1;
                    w_err_code = E_HEXNUM;
                end else if (w_field_done && r_field_index == 4'(HEX_FIELDS - 1)
                             && r_name_left < 32'd2) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_NAMELEN;
                end
            end
            PH_NAME: begin
                if (w_c == 8'h00) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_ZERO;
                end else if ((w_c >= 8'h09 && w_c <= 8'h0D) || w_space) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_SPACE;
                end else if (w_c < 8'h20 || w_c > 8'h7E) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_UNPRINT;
                end
            end
            PH_NUL: begin
                if (w_c != 8'h00) begin
                    w_err_hit  = 1'b1;
                    w_err_code = E_NOTERM;
                end else begin
                    w_hdr_done = (n_offset_low == 2'd0);
                end
            end
            PH_PAD1: begin
                w_hdr_done = (n_offset_low == 2'd0);
            end
            default: begin
            end
        endcase
    end

    assign n_offset_low = r_offset_low + 2'd1;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_phase         = r_phase;
        n_field_index   = r_field_index;
        n_digit_index   = r_digit_index;
        n_leading       = r_leading;
        n_field_value   = r_field_value;
        n_member_size   = r_member_size;
        n_name_left     = r_name_left;
        n_data_left     = r_data_left;
        n_trailer_match = r_trailer_match;
        n_name_position = r_name_position;
        n_err           = r_err;
        if (w_err_hit) begin
            // latch the first error and stay there
            n_phase = PH_ERROR;
            n_err   = w_err_code;
        end else begin
            case (r_phase)
                PH_MAGIC: begin
                    n_field_index = r_field_index + 4'd1;
                    if (r_field_index == 4'(MAGIC_LEN - 1)) begin
                        n_phase       = PH_HEX;
                        n_field_index = 4'd0;
                        n_digit_index = 3'd0;
                        n_leading     = 1'b1;
                        n_field_value = 32'd0;
                    end
                end
                PH_HEX: begin
                    n_field_value = w_shifted;
                    n_digit_index = r_digit_index + 3'd1;
                    if (!w_space) begin
                        n_leading = 1'b0;
                    end
                    if (w_field_done) begin
                        if (r_field_index == 4'(SIZE_FIELD)) begin
                            n_member_size = w_shifted;
                        end
                        if (r_field_index == 4'(NAME_FIELD)) begin
                            n_name_left = w_shifted;
                        end
                        n_digit_index = 3'd0;
                        n_leading     = 1'b1;
                        n_field_value = 32'd0;
                        n_field_index = r_field_index + 4'd1;
                        if (r_field_index == 4'(HEX_FIELDS - 1)) begin
                            // name length counts the NUL; hold only the characters
                            n_name_left     = r_name_left - 32'd1;
                            n_trailer_match = 1'b1;
                            n_name_position = 4'd0;
                            n_phase         = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    if (r_name_position >= 4'(TRAILER_LEN)
                        || w_c != trailer_char(r_name_position)) begin
                        n_trailer_match = 1'b0;
                    end
                    if (r_name_position <= 4'(TRAILER_LEN)) begin
                        n_name_position = r_name_position + 4'd1;
                    end
                    n_name_left = r_name_left - 32'd1;
                    if (r_name_left == 32'd1) begin
                        n_phase = PH_NUL;
                    end
                end
                PH_NUL, PH_PAD1: begin
                    if (w_hdr_done) begin
                        if (w_is_trailer) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_data_left = r_member_size;
                            if (r_member_size != 32'd0) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase       = PH_MAGIC;
                                n_field_index = 4'd0;
                            end
                        end
                    end else begin
                        n_phase = PH_PAD1;
                    end
                end
                PH_DATA: begin
                    n_data_left = r_data_left - 32'd1;
                    if (w_data_last) begin
                        if (n_offset_low == 2'd0) begin
                            n_phase       = PH_MAGIC;
                            n_field_index = 4'd0;
                        end else begin
                            n_phase = PH_PAD2;
                        end
                    end
                end
                PH_PAD2: begin
                    if (n_offset_low == 2'd0) begin
                        n_phase       = PH_MAGIC;
                        n_field_index = 4'd0;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result fields
    // ---------------------------------------------------------------
    always_comb begin
        n_kind          = K_HEADER;
        n_byte_out      = 8'd0;
        n_member_length = 32'd0;
        n_error_code    = E_NONE;
        n_last_data     = 1'b0;
        if (w_err_hit) begin
            n_kind       = K_ERROR;
            n_error_code = w_err_code;
        end else begin
            case (r_phase)
                PH_NAME: begin
                    n_kind     = K_NAME;
                    n_byte_out = w_c;
                end
                PH_NUL, PH_PAD1: begin
                    if (w_hdr_done) begin
                        if (w_is_trailer) begin
                            n_kind = K_TRAILER;
                        end else begin
                            n_kind          = K_START;
                            n_member_length = r_member_size;
                        end
                    end else if (r_phase == PH_PAD1) begin
                        n_kind = K_PAD;
                    end
                end
                PH_DATA: begin
                    n_kind      = K_DATA;
                    n_byte_out  = w_c;
                    n_last_data = w_data_last;
                end
                PH_PAD2: begin
                    n_kind = K_PAD;
                end
                PH_DONE: begin
                    n_kind = K_IGNORED;
                end
                PH_ERROR: begin
                    n_kind       = K_ERROR;
                    n_error_code = r_err;
                end
                default: begin
                    n_kind = K_HEADER;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers: state advances only on an accepted transfer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_MAGIC;
            r_field_index   <= 4'd0;
            r_digit_index   <= 3'd0;
            r_leading       <= 1'b1;
            r_field_value   <= 32'd0;
            r_member_size   <= 32'd0;
            r_name_left     <= 32'd0;
            r_data_left     <= 32'd0;
            r_offset_low    <= 2'd0;
            r_trailer_match <= 1'b1;
            r_name_position <= 4'd0;
            r_err           <= E_NONE;
            r_valid         <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase         <= n_phase;
                r_field_index   <= n_field_index;
                r_digit_index   <= n_digit_index;
                r_leading       <= n_leading;
                r_field_value   <= n_field_value;
                r_member_size   <= n_member_size;
                r_name_left     <= n_name_left;
                r_data_left     <= n_data_left;
                r_offset_low    <= n_offset_low;
                r_trailer_match <= n_trailer_match;
                r_name_position <= n_name_position;
                r_err           <= n_err;
                r_valid         <= 1'b1;
            end else if (!i_stall) begin
                // result taken, nothing new to hold
                r_valid <= 1'b0;
            end
        end
    end

    // payload of the result register; holds while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind          <= n_kind;
            r_byte_out      <= n_byte_out;
            r_member_length <= n_member_length;
            r_error_code    <= n_error_code;
            r_last_data     <= n_last_data;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_byte_out      = r_byte_out;
    assign o_member_length = r_member_length;
    assign o_error_code    = r_error_code;
    assign o_last_data     = r_last_data;

endmodule

[sv/cnsp_checker.sv]
// Port-level assertions for the newc cpio stream parser, bound to the top
// level. Depends on cnsp_pkg.

module cnsp_checker
    import cnsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_byte_out,
    input logic [31:0] o_member_length,
    input logic [3:0]  o_error_code,
    input logic        o_last_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_error_code)
                               && $stable(o_byte_out) && $stable(o_member_length))
        else $error("stalled result changed");

    // input stall only while a result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // an error code goes with the error kind and only with it
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == K_ERROR) == (o_error_code != E_NONE)))
        else $error("error code does not match kind");

    // errors are sticky: the next result after an error is the same error
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_ERROR |=> !o_valid
            || (o_kind == K_ERROR && o_error_code == $past(o_error_code)))
        else $error("error did not stick");

    // last-data flag and member length appear only with their kinds
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_last_data || o_kind == K_DATA)
                    && (o_member_length == 32'd0 || o_kind == K_START))
        else $error("field set outside its kind");

endmodule

bind cpio_newc_stream_parser_unit cnsp_checker u_cnsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_byte_out      (o_byte_out),
    .o_member_length (o_member_length),
    .o_error_code    (o_error_code),
    .o_last_data     (o_last_data)
);
